// ===== src/dbs_pkg.sv =====
package dbs_pkg;

   // Default and fixed sizes of the frame store.
   localparam int MAX_COLUMNS_DEF = 128;
   localparam int MAX_ROWS        = 128;
   localparam int ROW_LIMIT       = (MAX_ROWS < 128) ? MAX_ROWS : 128;

   // Field widths of the item interfaces.
   localparam int POS_W     = 7;
   localparam int SIZE_W    = 8;
   localparam int PIX_W     = 8;
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 2;

   // Depth of the queue between the pixel front and the column back end.
   localparam int QUEUE_DEPTH = 4;

   // Register reset values.
   localparam logic [CSR_W-1:0] COLUMNS_RESET   = 8'd128;
   localparam logic [CSR_W-1:0] ROWS_RESET      = 8'd128;
   localparam logic [CSR_W-1:0] THRESHOLD_RESET = 8'd127;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COLUMNS   = 2'd0,
      REG_ROWS      = 2'd1,
      REG_THRESHOLD = 2'd2
   } csr_reg_type;

   // Frame geometry after saturation, and the black threshold.
   typedef struct packed {
      logic [POS_W-1:0] last_col;
      logic [POS_W-1:0] last_row;
      logic [PIX_W-1:0] threshold;
   } frame_cfg_type;

   // One classified pixel handed from the front to the back end.
   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             black;
      logic             frame_end;
   } pix_item_type;

   // A box under construction or waiting to go out.
   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [SIZE_W-1:0] width;
      logic [POS_W-1:0]  top;
      logic [POS_W-1:0]  bottom;
   } box_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      ST_PIXEL,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } back_state_type;

   // Height from the top black row through the bottom black row.
   function automatic logic [SIZE_W-1:0] box_height(box_type b);
      return {1'b0, b.bottom} - {1'b0, b.top} + 8'd1;
   endfunction

endpackage

// ===== src/digit_box_segmenter.sv =====
// Pixels are taken one per cycle while the queue has room and reach the column store as they
// leave the queue. Once the final pixel leaves the queue, the walk reads and then evaluates
// each column in turn and ends with a finish step. Next-frame pixels fill the queue, then input
// stalls until the walk ends, and longer under result stalls.
// Synchronous active-high reset loads 128 columns, 128 rows and threshold 127 and clears the
// counters, the column flags, the queue and the result register.
module digit_box_segmenter #(
   parameter int MAX_COLUMNS = dbs_pkg::MAX_COLUMNS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dbs_pkg::PIX_W-1:0]     req_pixel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_box_valid,
   output logic [dbs_pkg::POS_W-1:0]     rsp_box_x,
   output logic [dbs_pkg::SIZE_W-1:0]    rsp_box_width,
   output logic [dbs_pkg::POS_W-1:0]     rsp_box_top,
   output logic [dbs_pkg::SIZE_W-1:0]    rsp_box_height,
   output logic                          rsp_last_box,
   input  logic                          csr_write_enable,
   input  logic [dbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dbs_pkg::CSR_W-1:0]     csr_write_data
);

   logic [dbs_pkg::CSR_W-1:0] columns_ff;
   logic [dbs_pkg::CSR_W-1:0] rows_ff;
   logic [dbs_pkg::CSR_W-1:0] threshold_ff;
   logic [dbs_pkg::CSR_W-1:0] columns_sat;
   logic [dbs_pkg::CSR_W-1:0] rows_sat;
   dbs_pkg::frame_cfg_type    cfg;
   logic                      flush;
   logic                      item_push;
   dbs_pkg::pix_item_type     item;
   logic                      queue_full;
   logic                      q_valid;
   logic                      q_pop;
   dbs_pkg::pix_item_type     q_item;

   // Any register write abandons the frame in progress.
   assign flush = csr_write_enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= dbs_pkg::COLUMNS_RESET;
         rows_ff      <= dbs_pkg::ROWS_RESET;
         threshold_ff <= dbs_pkg::THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (dbs_pkg::csr_reg_type'(csr_index))
            dbs_pkg::REG_COLUMNS:   columns_ff   <= csr_write_data;
            dbs_pkg::REG_ROWS:      rows_ff      <= csr_write_data;
            dbs_pkg::REG_THRESHOLD: threshold_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Saturate the frame size to what the store and the row fields can hold.
   always_comb begin
      columns_sat = columns_ff;
      if (columns_ff == '0) begin
         columns_sat = 8'd1;
      end else if (columns_ff > dbs_pkg::CSR_W'(MAX_COLUMNS)) begin
         columns_sat = dbs_pkg::CSR_W'(MAX_COLUMNS);
      end
      rows_sat = rows_ff;
      if (rows_ff == '0) begin
         rows_sat = 8'd1;
      end else if (rows_ff > dbs_pkg::CSR_W'(dbs_pkg::ROW_LIMIT)) begin
         rows_sat = dbs_pkg::CSR_W'(dbs_pkg::ROW_LIMIT);
      end
      cfg.last_col  = dbs_pkg::POS_W'(columns_sat - 8'd1);
      cfg.last_row  = dbs_pkg::POS_W'(rows_sat - 8'd1);
      cfg.threshold = threshold_ff;
   end

   dbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .flush           (flush),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .queue_full      (queue_full),
      .item_push       (item_push),
      .item            (item)
   );

   dbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .flush      (flush),
      .push       (item_push),
      .push_item  (item),
      .full       (queue_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_item)
   );

   dbs_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .flush          (flush),
      .last_col       (cfg.last_col),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_box_valid  (rsp_box_valid),
      .rsp_box_x      (rsp_box_x),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_height (rsp_box_height),
      .rsp_last_box   (rsp_last_box)
   );

endmodule

// ===== src/dbs_front.sv =====
module dbs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    flush,
   input  dbs_pkg::frame_cfg_type  cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [dbs_pkg::PIX_W-1:0] req_pixel_value,
   input  logic                    queue_full,
   output logic                    item_push,
   output dbs_pkg::pix_item_type   item
);

   logic [dbs_pkg::POS_W-1:0] col_ff;
   logic [dbs_pkg::POS_W-1:0] col_in;
   logic [dbs_pkg::POS_W-1:0] row_ff;
   logic [dbs_pkg::POS_W-1:0] row_in;
   logic                      accept;
   logic                      col_end;
   logic                      row_end;

   // An item is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign item_push = accept;

   assign col_end = (col_ff == cfg.last_col);
   assign row_end = (row_ff == cfg.last_row);

   // Classify the pixel and tag it with its position in the frame.
   always_comb begin
      item.col       = col_ff;
      item.row       = row_ff;
      item.black     = (req_pixel_value <= cfg.threshold);
      item.frame_end = col_end && row_end;
   end

   // Raster position of the next pixel.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + 7'd1;
         end else begin
            col_in = col_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== src/dbs_queue.sv =====
module dbs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  flush,
   input  logic                  push,
   input  dbs_pkg::pix_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output dbs_pkg::pix_item_type head_item
);

   localparam int DEPTH = dbs_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dbs_pkg::pix_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/dbs_back.sv =====
module dbs_back #(
   parameter int MAX_COLUMNS = dbs_pkg::MAX_COLUMNS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       flush,
   input  logic [dbs_pkg::POS_W-1:0]  last_col,
   input  logic                       q_valid,
   input  dbs_pkg::pix_item_type      q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_box_valid,
   output logic [dbs_pkg::POS_W-1:0]  rsp_box_x,
   output logic [dbs_pkg::SIZE_W-1:0] rsp_box_width,
   output logic [dbs_pkg::POS_W-1:0]  rsp_box_top,
   output logic [dbs_pkg::SIZE_W-1:0] rsp_box_height,
   output logic                       rsp_last_box
);

   localparam int COL_W = $clog2(MAX_COLUMNS);

   dbs_pkg::back_state_type   state_ff;
   dbs_pkg::back_state_type   state_in;

   // Column store: black flags in flip-flops, row bounds in memories.
   logic [MAX_COLUMNS-1:0]    has_black_ff;
   logic [dbs_pkg::POS_W-1:0] first_mem [MAX_COLUMNS];
   logic [dbs_pkg::POS_W-1:0] last_mem [MAX_COLUMNS];
   logic                      hb_rd_ff;
   logic [dbs_pkg::POS_W-1:0] first_rd_ff;
   logic [dbs_pkg::POS_W-1:0] last_rd_ff;

   // Column walk.
   logic [COL_W-1:0]          x_ff;
   dbs_pkg::box_type          run_ff;
   logic                      run_active_ff;
   dbs_pkg::box_type          pend_ff;
   logic                      pend_valid_ff;

   // Result register.
   logic                       out_valid_ff;
   logic                       out_box_valid_ff;
   logic [dbs_pkg::POS_W-1:0]  out_x_ff;
   logic [dbs_pkg::SIZE_W-1:0] out_width_ff;
   logic [dbs_pkg::POS_W-1:0]  out_top_ff;
   logic [dbs_pkg::SIZE_W-1:0] out_height_ff;
   logic                       out_last_ff;

   logic [COL_W-1:0]          item_col;
   logic                      col_end;
   logic                      out_free;
   dbs_pkg::box_type          merged;
   dbs_pkg::box_type          new_box;
   logic                      new_valid;
   logic                      eval_hold;
   logic                      walk_start;
   logic                      col_step;
   logic                      clear_flags;
   logic                      out_load;
   dbs_pkg::box_type          out_box;
   logic                      out_box_valid;
   logic                      out_last;
   logic [dbs_pkg::SIZE_W-1:0] out_height;

   assign item_col = q_item.col[COL_W-1:0];
   assign col_end  = (dbs_pkg::POS_W'(x_ff) == last_col);
   assign out_free = !out_valid_ff || !rsp_stall;

   // Current column merged into the run, or opening a new run.
   always_comb begin
      if (run_active_ff) begin
         merged.x      = run_ff.x;
         merged.width  = run_ff.width + 8'd1;
         merged.top    = (first_rd_ff < run_ff.top) ? first_rd_ff : run_ff.top;
         merged.bottom = (last_rd_ff > run_ff.bottom) ? last_rd_ff : run_ff.bottom;
      end else begin
         merged.x      = dbs_pkg::POS_W'(x_ff);
         merged.width  = 8'd1;
         merged.top    = first_rd_ff;
         merged.bottom = last_rd_ff;
      end
   end

   // A run closes at an empty column or at the last column.
   assign new_valid = (run_active_ff && !hb_rd_ff) || (hb_rd_ff && col_end);
   assign new_box   = (run_active_ff && !hb_rd_ff) ? run_ff : merged;
   assign eval_hold = new_valid && pend_valid_ff && !out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbs_pkg::ST_PIXEL: begin
            if (q_valid && q_item.frame_end) begin
               state_in = dbs_pkg::ST_READ;
            end
         end
         dbs_pkg::ST_READ: begin
            state_in = dbs_pkg::ST_EVAL;
         end
         dbs_pkg::ST_EVAL: begin
            if (!eval_hold) begin
               state_in = col_end ? dbs_pkg::ST_FINISH : dbs_pkg::ST_READ;
            end
         end
         dbs_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = dbs_pkg::ST_PIXEL;
            end
         end
         default: state_in = dbs_pkg::ST_PIXEL;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      q_pop         = 1'b0;
      walk_start    = 1'b0;
      col_step      = 1'b0;
      clear_flags   = 1'b0;
      out_load      = 1'b0;
      out_box       = pend_ff;
      out_box_valid = 1'b1;
      out_last      = 1'b0;
      unique case (state_ff)
         dbs_pkg::ST_PIXEL: begin
            q_pop      = q_valid;
            walk_start = q_valid && q_item.frame_end;
         end
         dbs_pkg::ST_READ: begin
         end
         dbs_pkg::ST_EVAL: begin
            col_step = !eval_hold;
            out_load = new_valid && pend_valid_ff && out_free;
         end
         dbs_pkg::ST_FINISH: begin
            out_load      = out_free;
            clear_flags   = out_free;
            out_box_valid = pend_valid_ff;
            out_last      = 1'b1;
            if (!pend_valid_ff) begin
               out_box = '0;
            end
         end
         default: begin
         end
      endcase
      out_height = out_box_valid ? dbs_pkg::box_height(out_box) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         state_ff <= dbs_pkg::ST_PIXEL;
      end else begin
         state_ff <= state_in;
      end
   end

   // Per-column black flags; cleared at the end of each frame.
   always_ff @(posedge clock) begin
      if (reset || flush || clear_flags) begin
         has_black_ff <= '0;
      end else if (q_pop && q_item.black) begin
         has_black_ff[item_col] <= 1'b1;
      end
   end

   // Row bound memories with registered reads at the walk column.
   always_ff @(posedge clock) begin
      if (q_pop && q_item.black) begin
         last_mem[item_col] <= q_item.row;
         if (!has_black_ff[item_col]) begin
            first_mem[item_col] <= q_item.row;
         end
      end
      first_rd_ff <= first_mem[x_ff];
      last_rd_ff  <= last_mem[x_ff];
      hb_rd_ff    <= has_black_ff[x_ff];
   end

   // Walk position, current run and the box held back for the last mark.
   always_ff @(posedge clock) begin
      if (reset || flush) begin
         x_ff          <= '0;
         run_active_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (walk_start) begin
            x_ff          <= '0;
            run_active_ff <= 1'b0;
         end else if (col_step) begin
            if (!col_end) begin
               x_ff <= x_ff + 1'b1;
            end
            run_active_ff <= hb_rd_ff;
         end
         if (clear_flags) begin
            pend_valid_ff <= 1'b0;
         end else if (col_step && new_valid) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (col_step && hb_rd_ff) begin
         run_ff <= merged;
      end
      if (col_step && new_valid) begin
         pend_ff <= new_box;
      end
   end

   // Result register; a new item is loaded as the old one leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_box_valid_ff <= out_box_valid;
         out_x_ff         <= out_box.x;
         out_width_ff     <= out_box.width;
         out_top_ff       <= out_box.top;
         out_height_ff    <= out_height;
         out_last_ff      <= out_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_box_valid  = out_box_valid_ff;
   assign rsp_box_x      = out_x_ff;
   assign rsp_box_width  = out_width_ff;
   assign rsp_box_top    = out_top_ff;
   assign rsp_box_height = out_height_ff;
   assign rsp_last_box   = out_last_ff;

endmodule

// ===== src/dbs_checker.sv =====
module dbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_box_valid,
   input logic [dbs_pkg::POS_W-1:0]     rsp_box_x,
   input logic [dbs_pkg::SIZE_W-1:0]    rsp_box_width,
   input logic [dbs_pkg::POS_W-1:0]     rsp_box_top,
   input logic [dbs_pkg::SIZE_W-1:0]    rsp_box_height,
   input logic                          rsp_last_box
);

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_box_valid) && $stable(rsp_box_x)
         && $stable(rsp_box_width) && $stable(rsp_box_top) && $stable(rsp_box_height)
         && $stable(rsp_last_box))
      else $error("result item changed while stalled");

   // No result is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // An empty frame gives a single all-zero item that closes the frame.
   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_box_valid |-> rsp_last_box && rsp_box_x == '0 && rsp_box_width == '0
         && rsp_box_top == '0 && rsp_box_height == '0)
      else $error("invalid box item is not an all-zero final item");

   // A real box covers at least one column and one row.
   a_box_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_box_valid |-> rsp_box_width != '0 && rsp_box_height != '0)
      else $error("box with zero width or height");

endmodule

bind digit_box_segmenter dbs_checker u_checker (.*);
